// ===== sv/wans_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Weekday alarm selector package
// Shared types, command codes, reciprocal constants and small helper
// functions for the weekday alarm next-time selector.
// ----------------------------------------------------------------------------
package wans_pkg;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_DAY,
		ST_MUL_DS,
		ST_TOD,
		ST_MUL_MIN,
		ST_MUL_HR,
		ST_HM,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} wans_state_t;

	// Command codes (code 3 is unused and changes nothing)
	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_COMPUTE = 2'd1;
	localparam logic [1:0] CMD_CHECK   = 2'd2;

	// One alarm table entry, 20 bits
	typedef struct packed {
		logic       enabled;
		logic       once;
		logic [6:0] day_mask;
		logic [4:0] hour;
		logic [5:0] minute;
	} alarm_entry_t;

	// Calendar view of the current time
	typedef struct packed {
		logic [2:0] weekday;
		logic [4:0] hour;
		logic [5:0] minute;
	} now_clock_t;

	localparam int TimeW   = 33;
	localparam int OffsetW = 20;

	// Shared multiplier geometry
	localparam int MulAW = 25;
	localparam int MulBW = 26;
	localparam int MulPW = MulAW + MulBW;

	// floor(x / 675) = (x * DayRecip) >> 35 for x < 2**25
	localparam logic [MulBW-1:0] DayRecip = 26'd50903317;
	localparam logic [MulBW-1:0] DayOdd   = 26'd675;
	// floor(x / 60) = (x * MinRecip) >> 23 for x < 86400
	localparam logic [MulBW-1:0] MinRecip = 26'd139811;
	// floor(x / 60) = (x * HourRecip) >> 16 for x < 1440
	localparam logic [MulBW-1:0] HourRecip = 26'd1093;

	// Residue mod 7 of a 17-bit value: octal digits fold since 8 = 1 mod 7
	function automatic logic [2:0] mod7_17(input logic [16:0] v);
		logic [5:0] s1;
		logic [3:0] s2;
		logic [2:0] s3;
		s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
			+ 6'(v[16:15]);
		s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
		s3 = s2[2:0] + 3'(s2[3]);
		return (s3 == 3'd7) ? 3'd0 : s3;
	endfunction

	// Rotate a weekday mask so that bit j is the day j days after weekday
	function automatic logic [6:0] rot_mask(input logic [6:0] m, input logic [2:0] wd);
		logic [13:0] twice;
		twice = {m, m} >> wd;
		return twice[6:0];
	endfunction

	// Seconds in a given number of whole days, up to seven
	function automatic logic [OffsetW-1:0] day_secs(input logic [2:0] d);
		return OffsetW'(d) * 20'd86400;
	endfunction

endpackage
`default_nettype wire

// ===== sv/weekday_alarm_next_time_selector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Weekday alarm next-time selector
// Holds a table of weekday alarms, finds the earliest next firing second
// for a given local time, and reports whether the stored alarm is due.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  command, alarm_slot, entry_*,
//                                            now_seconds
//   out      from block out_valid / out_stall next_alarm_time,
//                                            next_alarm_slot, ringing
//   cfg      to block   cfg_valid / cfg_ready cfg_data (trigger tolerance)
//
// A compute command runs six setup steps, four of them on the shared
// multiplier, that split the time into day, weekday, hour and minute, then
// the scan visits one table entry per cycle.
// Write, check and unused commands skip the setup and the scan.
// One item is in work at a time; in_stall is high until its result sits in
// the output register, which holds it while out_stall is high.
// Reset clears the table, the stored alarm and sets the tolerance to 20.
// ----------------------------------------------------------------------------
module weekday_alarm_next_time_selector #(
	parameter int ALARM_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [2:0]  alarm_slot,
	input  logic        entry_enabled,
	input  logic        entry_once,
	input  logic [6:0]  entry_day_mask,
	input  logic [4:0]  entry_hour,
	input  logic [5:0]  entry_minute,
	input  logic [31:0] now_seconds,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [32:0] next_alarm_time,
	output logic [2:0]  next_alarm_slot,
	output logic        ringing,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import wans_pkg::*;

	localparam int IdxW = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;

	wans_state_t state_q, state_d;

	alarm_entry_t table_q [ALARM_COUNT];
	alarm_entry_t wr_entry;

	logic [31:0]        now_q;
	logic [MulPW-1:0]   prod_q;
	logic [15:0]        day_q;
	logic [31:0]        ds_q;
	logic [16:0]        tod_q;
	logic [10:0]        nmin_q;
	now_clock_t         tnow_q;

	logic [MulAW-1:0]   mul_a;
	logic [MulBW-1:0]   mul_b;
	logic [MulPW-1:0]   mul_p;
	logic               mul_en;

	logic [IdxW-1:0]    scan_idx_q;
	logic               scan_last;
	logic               fire_ok_c;
	logic [OffsetW-1:0] offset_c;
	logic               vld_s1;
	logic               fire_ok_s1;
	logic [OffsetW-1:0] off_s1;
	logic [IdxW-1:0]    idx_s1;

	logic               found_q;
	logic [TimeW-1:0]   best_time_q;
	logic [IdxW-1:0]    best_idx_q;
	logic [TimeW-1:0]   cand_time;
	logic               take;

	logic [TimeW-1:0]   stored_time_q;
	logic [2:0]         stored_slot_q;
	logic [7:0]         tol_q;
	logic               ring_q;
	logic               ring_c;

	logic               out_valid_q;
	logic [TimeW-1:0]   out_time_q;
	logic [2:0]         out_slot_q;
	logic               out_ring_q;
	logic               out_load;
	logic               in_xfer;

	// Handshakes
	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign out_valid       = out_valid_q;
	assign next_alarm_time = out_time_q;
	assign next_alarm_slot = out_slot_q;
	assign ringing         = out_ring_q;

	assign wr_entry = '{enabled: entry_enabled, once: entry_once, day_mask: entry_day_mask,
		hour: entry_hour, minute: entry_minute};

	assign scan_last = (scan_idx_q == IdxW'(ALARM_COUNT - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = (command == CMD_COMPUTE) ? ST_MUL_DAY : ST_DONE;
				end
			end
			ST_MUL_DAY: state_d = ST_MUL_DS;
			ST_MUL_DS:  state_d = ST_TOD;
			ST_TOD:     state_d = ST_MUL_MIN;
			ST_MUL_MIN: state_d = ST_MUL_HR;
			ST_MUL_HR:  state_d = ST_HM;
			ST_HM:      state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:   state_d = ST_DONE;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: multiplier operands and result load
	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		mul_en   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_MUL_DAY: begin
				mul_a  = now_q[31:7];
				mul_b  = DayRecip;
				mul_en = 1'b1;
			end
			ST_MUL_DS: begin
				mul_a  = MulAW'(prod_q[50:35]);
				mul_b  = DayOdd;
				mul_en = 1'b1;
			end
			ST_MUL_MIN: begin
				mul_a  = MulAW'(tod_q);
				mul_b  = MinRecip;
				mul_en = 1'b1;
			end
			ST_MUL_HR: begin
				mul_a  = MulAW'(prod_q[33:23]);
				mul_b  = HourRecip;
				mul_en = 1'b1;
			end
			ST_DONE: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
			end
		endcase
	end

	// Shared multiplier
	assign mul_p = MulPW'(mul_a) * MulPW'(mul_b);

	// Per-entry firing offset
	wans_fire_offset u_fire (
		.entry     (table_q[scan_idx_q]),
		.now_clock (tnow_q),
		.fire_ok   (fire_ok_c),
		.offset    (offset_c)
	);

	// Compare stage: keep the earliest, ties keep the lower index
	assign cand_time = TimeW'(ds_q) + TimeW'(off_s1);
	assign take      = vld_s1 && fire_ok_s1 && (!found_q || (cand_time < best_time_q));

	// Due check for the stored alarm
	assign ring_c = (stored_time_q != '0) &&
		(stored_time_q < (TimeW'(now_seconds) + TimeW'(tol_q)));

	// Control state, table and stored alarm
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			scan_idx_q    <= '0;
			vld_s1        <= 1'b0;
			found_q       <= 1'b0;
			stored_time_q <= '0;
			stored_slot_q <= '0;
			tol_q         <= 8'd20;
			ring_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			for (int i = 0; i < ALARM_COUNT; i++) begin
				table_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;

			// Take a tolerance write
			if (cfg_valid) begin
				tol_q <= cfg_data;
			end

			// Write one table entry; slots past the table are dropped
			if (in_xfer && (command == CMD_WRITE)) begin
				for (int i = 0; i < ALARM_COUNT; i++) begin
					if ({3'b000, alarm_slot} == 6'(i)) begin
						table_q[i] <= wr_entry;
					end
				end
			end

			// Latch the due flag on each transfer
			if (in_xfer) begin
				ring_q <= (command == CMD_CHECK) && ring_c;
			end

			// Advance the scan index
			if (state_q == ST_HM) begin
				scan_idx_q <= '0;
			end else if (state_q == ST_SCAN) begin
				scan_idx_q <= scan_last ? '0 : scan_idx_q + 1'b1;
			end
			vld_s1 <= (state_q == ST_SCAN);

			// Track the best candidate
			if (state_q == ST_HM) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end

			// Commit the result of the scan
			if (state_q == ST_DRAIN) begin
				if (found_q || take) begin
					stored_time_q <= take ? cand_time : best_time_q;
					stored_slot_q <= take ? 3'(idx_s1) : 3'(best_idx_q);
				end else begin
					stored_time_q <= '0;
					stored_slot_q <= '0;
				end
			end

			// Hold or drop the output transfer
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			now_q <= now_seconds;
		end
		if (mul_en) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_MUL_DS) begin
			day_q <= prod_q[50:35];
		end
		if (state_q == ST_TOD) begin
			ds_q           <= {prod_q[24:0], 7'b0};
			tod_q          <= {now_q[16:7] - prod_q[9:0], now_q[6:0]};
			tnow_q.weekday <= mod7_17(17'(day_q) + 17'd3);
		end
		if (state_q == ST_MUL_HR) begin
			nmin_q <= prod_q[33:23];
		end
		if (state_q == ST_HM) begin
			tnow_q.hour   <= prod_q[20:16];
			tnow_q.minute <= 6'(nmin_q - 11'(prod_q[20:16]) * 11'd60);
		end

		// Scan pipeline stage
		fire_ok_s1 <= fire_ok_c;
		off_s1     <= offset_c;
		idx_s1     <= scan_idx_q;

		if (take) begin
			best_time_q <= cand_time;
			best_idx_q  <= idx_s1;
		end

		if (out_load) begin
			out_time_q <= stored_time_q;
			out_slot_q <= stored_slot_q;
			out_ring_q <= ring_q;
		end
	end

`ifndef SYNTHESIS
	a_xfer_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q != ST_IDLE)
		else $error("accepted item did not start work");

	a_ring_needs_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ringing |-> next_alarm_time != '0)
		else $error("ringing reported with no stored alarm");

	a_scan_from_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HM |=> state_q == ST_SCAN && scan_idx_q == '0)
		else $error("table scan did not start at entry zero");
`endif

endmodule
`default_nettype wire

// ===== sv/wans_fire_offset.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Alarm firing offset
// For one table entry, decides whether it can fire and gives its firing
// second as an offset from the start of the current day.
// ----------------------------------------------------------------------------
module wans_fire_offset (
	input  wans_pkg::alarm_entry_t        entry,
	input  wans_pkg::now_clock_t          now_clock,
	output logic                          fire_ok,
	output logic [wans_pkg::OffsetW-1:0]  offset
);
	import wans_pkg::*;

	logic       before_now;
	logic       after_now;
	logic [6:0] ahead;
	logic [2:0] days;

	// Compare alarm hour and minute with the current hour and minute
	assign before_now = (entry.hour < now_clock.hour) ||
		((entry.hour == now_clock.hour) && (entry.minute < now_clock.minute));
	assign after_now = (entry.hour > now_clock.hour) ||
		((entry.hour == now_clock.hour) && (entry.minute > now_clock.minute));

	assign ahead = rot_mask(entry.day_mask, now_clock.weekday);

	// Pick the number of days until the alarm fires
	always_comb begin
		days = 3'd7;
		if (entry.once) begin
			days = before_now ? 3'd1 : 3'd0;
		end else if (ahead[0] && after_now) begin
			days = 3'd0;
		end else begin
			for (int j = 6; j >= 1; j--) begin
				if (ahead[j]) begin
					days = 3'(j);
				end
			end
		end
	end

	// Skip disabled alarms and repeating alarms with no day set
	assign fire_ok = entry.enabled && (entry.once || (entry.day_mask != 7'd0));

	assign offset = OffsetW'(entry.hour) * 20'd3600 + OffsetW'(entry.minute) * 20'd60
		+ day_secs(days);

endmodule
`default_nettype wire

// ===== dv/weekday_alarm_next_time_selector_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weekday alarm selector checker
// Watches the command, result and tolerance channels of the selector. It
// keeps its own copy of the alarm table, the stored alarm and the
// tolerance, predicts one result per accepted command and compares every
// accepted result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module weekday_alarm_next_time_selector_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  command,
	input  logic [2:0]  alarm_slot,
	input  logic        entry_enabled,
	input  logic        entry_once,
	input  logic [6:0]  entry_day_mask,
	input  logic [4:0]  entry_hour,
	input  logic [5:0]  entry_minute,
	input  logic [31:0] now_seconds,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [32:0] next_alarm_time,
	input  logic [2:0]  next_alarm_slot,
	input  logic        ringing,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output int          mismatch_count,
	output int          pending_results,
	output int          due_count,
	output logic [32:0] predicted_next_time
);
	import wans_pkg::*;

	localparam int          TABLE_DEPTH     = 8;
	localparam int          REPORT_LIMIT    = 10;
	localparam logic [63:0] NEVER           = '1;
	localparam logic [63:0] DAY_SECONDS     = 64'd86400;
	localparam logic [7:0]  TOLERANCE_RESET = 8'd20;

	typedef struct packed {
		logic [32:0] alarm_time;
		logic [2:0]  slot;
		logic        due;
	} selector_result_t;

	alarm_entry_t     alarm_table [TABLE_DEPTH];
	logic [32:0]      stored_time;
	logic [2:0]       stored_slot;
	logic [7:0]       tolerance;
	selector_result_t awaiting_results [$];

	// Next firing second of one entry at the given local time, NEVER if none
	function automatic logic [63:0] next_firing_second(input alarm_entry_t entry,
		input logic [31:0] now);
		logic [63:0] tod, day_start, base, fire;
		int unsigned now_hour, now_minute, weekday;
		fire       = NEVER;
		tod        = 64'(now) % DAY_SECONDS;
		day_start  = 64'(now) - tod;
		now_hour   = int'(tod / 3600);
		now_minute = int'((tod % 3600) / 60);
		weekday    = int'((64'(now) / DAY_SECONDS + 3) % 7);
		// hour and minute count linearly, even beyond their clock range
		base = day_start + 64'(entry.hour) * 3600 + 64'(entry.minute) * 60;
		if (!entry.enabled) begin
			fire = NEVER;
		end else if (entry.once) begin
			// a one-time alarm slips to tomorrow only once its minute has passed
			if (entry.hour < now_hour || (entry.hour == now_hour && entry.minute < now_minute)) begin
				fire = base + DAY_SECONDS;
			end else begin
				fire = base;
			end
		end else if (entry.day_mask != '0) begin
			if (entry.day_mask[weekday] && (entry.hour > now_hour
				|| (entry.hour == now_hour && entry.minute > now_minute))) begin
				fire = base;
			end else begin
				// walk downward so the nearest masked day is the last one kept
				for (int d = 7; d >= 1; d--) begin
					if (entry.day_mask[(weekday + d) % 7]) begin
						fire = base + DAY_SECONDS * d;
					end
				end
			end
		end
		return fire;
	endfunction

	// Track the table, predict each command's result and compare results
	always @(posedge clk or negedge arst_n) begin : track
		logic [63:0]      best, fire;
		logic [2:0]       best_slot;
		logic             due;
		selector_result_t seen, want;
		if (!arst_n) begin
			foreach (alarm_table[i]) begin
				alarm_table[i] = '0;
			end
			stored_time = '0;
			stored_slot = '0;
			tolerance = TOLERANCE_RESET;
			awaiting_results.delete();
			mismatch_count = 0;
			due_count = 0;
		end else begin
			// compare a result transfer with the oldest prediction
			if (out_valid && !out_stall) begin
				seen = {next_alarm_time, next_alarm_slot, ringing};
				if (awaiting_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("Unexpected result at %0t: time %0d slot %0d ringing %0b",
							$realtime, seen.alarm_time, seen.slot, seen.due);
					end
				end else begin
					want = awaiting_results.pop_front();
					if (seen.alarm_time != want.alarm_time || seen.slot != want.slot
						|| seen.due != want.due) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT) begin
							$display("Mismatch at %0t: expected time %0d slot %0d ringing %0b,",
								$realtime, want.alarm_time, want.slot, want.due);
							$display("  got time %0d slot %0d ringing %0b",
								seen.alarm_time, seen.slot, seen.due);
						end
					end
				end
			end
			// take a tolerance write
			if (cfg_valid && cfg_ready) begin
				tolerance = cfg_data;
			end
			// apply a command transfer and queue its result
			if (in_valid && !in_stall) begin
				due = 1'b0;
				case (command)
					CMD_WRITE: begin
						alarm_table[alarm_slot] = '{entry_enabled, entry_once, entry_day_mask,
							entry_hour, entry_minute};
					end
					CMD_COMPUTE: begin
						best = NEVER;
						best_slot = '0;
						// strict compare keeps the lower index on ties
						for (int i = 0; i < TABLE_DEPTH; i++) begin
							fire = next_firing_second(alarm_table[i], now_seconds);
							if (fire < best) begin
								best = fire;
								best_slot = 3'(i);
							end
						end
						if (best == NEVER) begin
							best = '0;
							best_slot = '0;
						end
						stored_time = best[32:0];
						stored_slot = best_slot;
					end
					CMD_CHECK: begin
						due = stored_time != '0
							&& 64'(stored_time) < 64'(now_seconds) + 64'(tolerance);
					end
					default: begin
					end
				endcase
				if (due) begin
					due_count++;
				end
				awaiting_results.push_back('{stored_time, stored_slot, due});
			end
		end
		pending_results = awaiting_results.size();
		predicted_next_time = stored_time;
	end

endmodule

// ===== dv/weekday_alarm_next_time_selector_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weekday alarm selector testbench
// Drives alarm writes, next-alarm computes and ringing checks into the
// selector with random gaps and output stalls, including one long output
// hold-off. A directed opening covers the corner cases; random scenarios
// then write entries, compute near their alarm times and check ringing
// around the tolerance edge under several tolerance settings.
// ----------------------------------------------------------------------------
module weekday_alarm_next_time_selector_test;
	import wans_pkg::*;

	localparam logic [1:0]  CMD_UNUSED      = 2'd3;
	localparam int          PHASE_COUNT     = 5;
	localparam int          PHASE_ITEMS     = 250;
	localparam int          WATCHDOG_LIMIT  = 5000;
	localparam int          HOLD_OFF_CYCLES = 400;
	localparam int          SETTLE_CYCLES   = 20;
	localparam logic [7:0]  TOLERANCE_RESET = 8'd20;
	localparam logic [31:0] MONDAY_TEN      = 32'd381600;
	localparam logic [31:0] MONDAY_NOON     = 32'd388800;
	localparam logic [31:0] TUESDAY_START   = 32'd432000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  command;
	logic [2:0]  alarm_slot;
	logic        entry_enabled;
	logic        entry_once;
	logic [6:0]  entry_day_mask;
	logic [4:0]  entry_hour;
	logic [5:0]  entry_minute;
	logic [31:0] now_seconds;
	logic        out_valid;
	logic        out_stall;
	logic [32:0] next_alarm_time;
	logic [2:0]  next_alarm_slot;
	logic        ringing;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	int          mismatch_count;
	int          pending_results;
	int          due_count;
	logic [32:0] predicted_next_time;

	logic [7:0]  tolerance_now = TOLERANCE_RESET;
	logic [4:0]  written_hour [8] = '{default: '0};
	logic [5:0]  written_minute [8] = '{default: '0};
	int          sent_count [4] = '{default: 0};
	int          item_count = 0;
	int          settings_count = 0;
	int          idle_cycles = 0;
	bit          sender_calm = 1'b0;
	bit          pressure_go = 1'b0;
	bit          pressure_done = 1'b0;

	weekday_alarm_next_time_selector u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.alarm_slot      (alarm_slot),
		.entry_enabled   (entry_enabled),
		.entry_once      (entry_once),
		.entry_day_mask  (entry_day_mask),
		.entry_hour      (entry_hour),
		.entry_minute    (entry_minute),
		.now_seconds     (now_seconds),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.next_alarm_time (next_alarm_time),
		.next_alarm_slot (next_alarm_slot),
		.ringing         (ringing),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	weekday_alarm_next_time_selector_checker u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.command             (command),
		.alarm_slot          (alarm_slot),
		.entry_enabled       (entry_enabled),
		.entry_once          (entry_once),
		.entry_day_mask      (entry_day_mask),
		.entry_hour          (entry_hour),
		.entry_minute        (entry_minute),
		.now_seconds         (now_seconds),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.next_alarm_time     (next_alarm_time),
		.next_alarm_slot     (next_alarm_slot),
		.ringing             (ringing),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_data            (cfg_data),
		.mismatch_count      (mismatch_count),
		.pending_results     (pending_results),
		.due_count           (due_count),
		.predicted_next_time (predicted_next_time)
	);

	// 20 ns clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Idle length: mostly short, now and then long
	function automatic int random_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			return $urandom_range(1, 3);
		end else if (pick < 95) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Compute time: full random, near a written alarm, or at a day edge
	function automatic logic [31:0] pick_compute_now();
		int unsigned day;
		int          tod, slot, offset;
		day = $urandom_range(0, 49709);
		case ($urandom_range(0, 3))
			0: begin
				return $urandom;
			end
			1: begin
				slot = $urandom_range(0, 7);
				offset = $urandom_range(0, 120);
				tod = int'(written_hour[slot]) * 3600 + int'(written_minute[slot]) * 60 + offset - 60;
				if (tod < 0) begin
					tod = 0;
				end else if (tod > 86399) begin
					tod = 86399;
				end
			end
			2: begin
				tod = $urandom_range(0, 86399);
			end
			default: begin
				tod = ($urandom_range(0, 1) != 0) ? 86399 : 0;
			end
		endcase
		return day * 86400 + tod;
	endfunction

	// Check time: often around the ringing edge of the stored alarm, else before it or random
	function automatic logic [31:0] pick_check_now();
		longint target;
		int     delta, back;
		delta = $urandom_range(0, 4);
		back = $urandom_range(0, 90000);
		case ($urandom_range(0, 3))
			0, 1: begin
				target = longint'(predicted_next_time) - longint'(tolerance_now) + delta - 2;
			end
			2: begin
				target = longint'(predicted_next_time) - back;
			end
			default: begin
				return $urandom;
			end
		endcase
		if (target < 0) begin
			return '0;
		end else if (target > longint'(32'hFFFF_FFFF)) begin
			return '1;
		end
		return target[31:0];
	endfunction

	// Offer one command, hold it until the transfer, then sometimes idle for a while.
	// Entered and left at a falling edge.
	task automatic send_item(input logic [1:0] cmd, input logic [2:0] slot, input logic en,
		input logic once, input logic [6:0] mask, input logic [4:0] hour,
		input logic [5:0] minute, input logic [31:0] now);
		int gap;
		command <= cmd;
		alarm_slot <= slot;
		entry_enabled <= en;
		entry_once <= once;
		entry_day_mask <= mask;
		entry_hour <= hour;
		entry_minute <= minute;
		now_seconds <= now;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sent_count[cmd]++;
		if (cmd != CMD_UNUSED) begin
			item_count++;
		end
		if (cmd == CMD_WRITE) begin
			written_hour[slot] = hour;
			written_minute[slot] = minute;
		end
		gap = (sender_calm || $urandom_range(0, 2) != 0) ? 0 : random_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic write_entry(input logic [2:0] slot, input logic en, input logic once,
		input logic [6:0] mask, input logic [4:0] hour, input logic [5:0] minute);
		send_item(CMD_WRITE, slot, en, once, mask, hour, minute, $urandom);
	endtask

	task automatic send_timed(input logic [1:0] cmd, input logic [31:0] now);
		send_item(cmd, 3'($urandom), 1'($urandom), 1'($urandom), 7'($urandom), 5'($urandom),
			6'($urandom), now);
	endtask

	// Write the tolerance once the selector has drained
	task automatic set_tolerance(input logic [7:0] value);
		in_valid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		tolerance_now = value;
		settings_count++;
	endtask

	// One random scenario: entries, a compute, then checks; sometimes noise
	task automatic run_scenario();
		logic [6:0] mask;
		logic [4:0] hour;
		logic [5:0] minute;
		int         n;
		sender_calm = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 6) != 0) begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				case ($urandom_range(0, 4))
					0: mask = '0;
					1: mask = 7'h7F;
					2: mask = 7'(1 << $urandom_range(0, 6));
					default: mask = 7'($urandom);
				endcase
				hour = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
					: 5'($urandom_range(0, 23));
				minute = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63))
					: 6'($urandom_range(0, 59));
				write_entry(3'($urandom), $urandom_range(0, 9) != 0, $urandom_range(0, 2) == 0,
					mask, hour, minute);
			end
			send_timed(CMD_COMPUTE, pick_compute_now());
			n = $urandom_range(1, 4);
			repeat (n) send_timed(CMD_CHECK, pick_check_now());
		end else begin
			n = $urandom_range(1, 3);
			repeat (n) begin
				send_item(2'($urandom), 3'($urandom), 1'($urandom), 1'($urandom), 7'($urandom),
					5'($urandom), 6'($urandom), $urandom);
			end
		end
	endtask

	// Stimulus and verdict
	initial begin
		logic [7:0] phase_tolerance [PHASE_COUNT];
		int         phase_end;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_WRITE;
		alarm_slot = '0;
		entry_enabled = 1'b0;
		entry_once = 1'b0;
		entry_day_mask = '0;
		entry_hour = '0;
		entry_minute = '0;
		now_seconds = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		phase_tolerance = '{TOLERANCE_RESET, 8'd0, 8'd255, 8'($urandom_range(2, 254)), 8'd1};
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table: nothing pending, and a zero stored time never rings
		send_timed(CMD_COMPUTE, $urandom);
		send_timed(CMD_CHECK, 32'hFFFF_FFFF);
		// every day, once-only, disabled, empty mask, out-of-range time
		write_entry(3'd7, 1'b1, 1'b0, 7'h7F, 5'd23, 6'd59);
		write_entry(3'd0, 1'b1, 1'b1, 7'h00, 5'd0, 6'd0);
		write_entry(3'd1, 1'b0, 1'b1, 7'h7F, 5'd12, 6'd30);
		write_entry(3'd2, 1'b1, 1'b0, 7'h00, 5'd1, 6'd1);
		write_entry(3'd3, 1'b1, 1'b0, 7'h01, 5'd31, 6'd63);
		// epoch start: a once-only alarm at midnight lands on second zero
		send_timed(CMD_COMPUTE, 32'd0);
		send_timed(CMD_CHECK, 32'd0);
		// ringing just outside and just inside the tolerance
		send_timed(CMD_COMPUTE, MONDAY_NOON);
		send_timed(CMD_CHECK, 32'(predicted_next_time - tolerance_now));
		send_timed(CMD_CHECK, 32'(predicted_next_time - tolerance_now + 1));
		// two equal Monday alarms already past today, one beyond the clock
		write_entry(3'd4, 1'b1, 1'b1, 7'h7F, 5'd24, 6'd60);
		write_entry(3'd5, 1'b1, 1'b0, 7'h01, 5'd11, 6'd0);
		write_entry(3'd6, 1'b1, 1'b0, 7'h01, 5'd11, 6'd0);
		write_entry(3'd7, 1'b0, 1'b0, 7'h7F, 5'd23, 6'd59);
		send_timed(CMD_COMPUTE, MONDAY_NOON);
		send_timed(CMD_COMPUTE, MONDAY_TEN);
		// alarm minute equal to the current minute
		send_timed(CMD_COMPUTE, TUESDAY_START);
		send_timed(CMD_CHECK, TUESDAY_START);
		write_entry(3'd2, 1'b1, 1'b0, 7'h7F, 5'd0, 6'd0);
		send_timed(CMD_COMPUTE, TUESDAY_START + 32'd30);
		// top of the time range
		send_timed(CMD_COMPUTE, 32'hFFFF_FFFF);
		send_timed(CMD_CHECK, 32'hFFFF_FFFF);
		send_item(CMD_UNUSED, '1, 1'b1, 1'b1, '1, '1, '1, '1);

		// random phases, one tolerance setting each
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			if (phase > 0) begin
				set_tolerance(phase_tolerance[phase]);
			end
			if (phase == 1) begin
				pressure_go = 1'b1;
			end
			phase_end = item_count + PHASE_ITEMS;
			while (item_count < phase_end) run_scenario();
		end

		// drain, then let the block settle
		in_valid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d write, %0d compute, %0d check, %0d unused command transfers;",
			sent_count[CMD_WRITE], sent_count[CMD_COMPUTE], sent_count[CMD_CHECK],
			sent_count[CMD_UNUSED]);
		$display("%0d checks found the alarm due, %0d tolerance writes, one %0d-cycle hold-off.",
			due_count, settings_count, HOLD_OFF_CYCLES);
		if (mismatch_count == 0 && pending_results == 0) begin
			$display("weekday_alarm_next_time_selector test passed");
		end else begin
			$display("weekday_alarm_next_time_selector test failed");
		end
		$finish;
	end

	// Result side: stretches of random stalls or none, plus one long hold-off
	initial begin
		int hold_left, stall_left, stretch_left;
		bit calm;
		hold_left = 0;
		stall_left = 0;
		stretch_left = 0;
		calm = 1'b0;
		out_stall = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (pressure_go && !pressure_done) begin
				hold_left = HOLD_OFF_CYCLES;
				pressure_done = 1'b1;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				if (stretch_left == 0) begin
					calm = ($urandom_range(0, 3) == 0);
					stretch_left = $urandom_range(20, 200);
				end
				stretch_left--;
				if (!calm && $urandom_range(0, 3) == 0) begin
					stall_left = random_gap() - 1;
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
			|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("weekday_alarm_next_time_selector test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ===== sim.f =====
sv/wans_pkg.sv
sv/wans_fire_offset.sv
sv/weekday_alarm_next_time_selector.sv
dv/weekday_alarm_next_time_selector_checker.sv
dv/weekday_alarm_next_time_selector_test.sv
